// ----- src/pic_pkg.sv -----
// Shared types and constants for the projective inlier counter.
// No dependencies; used by every module under src.
package pic_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int PIDX_W     = 12;
    localparam int CNT_W      = 13;

    localparam int COEF_W = 32;
    localparam int COORD_W = 16;
    localparam int Q_W    = 49;
    localparam int D_W    = 64;
    localparam int SQ_W   = 128;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = 2;
    localparam int MQ_CW    = 3;

    localparam int OUT_DEPTH = 16;
    localparam int OUT_AW    = 4;
    localparam int OUT_CW    = 5;

    typedef enum logic [2:0] {
        CFG_COEF_PAIR_A       = 3'd0,
        CFG_COEF_PAIR_B       = 3'd1,
        CFG_COEF_PAIR_C       = 3'd2,
        CFG_COEF_PAIR_D       = 3'd3,
        CFG_COEF_BOTTOM_RIGHT = 3'd4,
        CFG_DIST_THRESHOLD    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] left_x;
        logic signed [COORD_W-1:0] left_y;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic                      last_pair;
    } t_pair_in;

    typedef struct packed {
        logic              is_inlier;
        logic [PIDX_W-1:0] point_index;
        logic [CNT_W-1:0]  inlier_count;
        logic              set_done;
    } t_result;

    typedef struct packed {
        logic signed [COEF_W-1:0] m00;
        logic signed [COEF_W-1:0] m01;
        logic signed [COEF_W-1:0] m02;
        logic signed [COEF_W-1:0] m10;
        logic signed [COEF_W-1:0] m11;
        logic signed [COEF_W-1:0] m12;
        logic signed [COEF_W-1:0] m20;
        logic signed [COEF_W-1:0] m21;
        logic signed [COEF_W-1:0] m22;
    } t_matrix;

    // projected pair, handed from front to back
    typedef struct packed {
        logic signed [Q_W-1:0]     q0;
        logic signed [Q_W-1:0]     q1;
        logic signed [Q_W-1:0]     q2;
        logic signed [COORD_W-1:0] right_x;
        logic signed [COORD_W-1:0] right_y;
        logic                      last_pair;
    } t_proj;

endpackage

// ----- src/pic_front.sv -----
// Front end: accepts point pairs and maps the left point through the matrix.
// Depends on pic_pkg; feeds pic_mid_queue.
module pic_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  pic_pkg::t_pair_in          i_pair,
    input  pic_pkg::t_matrix           i_mat,
    input  logic [pic_pkg::MQ_CW-1:0]  i_q_count,
    output logic                       o_wr_valid,
    output pic_pkg::t_proj             o_wr_data
);

    localparam int P_W = 48;

    logic                  r_f0_v;
    pic_pkg::t_pair_in     r_f0_pair;
    logic                  r_f1_v;
    logic signed [P_W-1:0] r_p00, r_p01, r_p10, r_p11, r_p20, r_p21;
    logic signed [pic_pkg::COEF_W-1:0]  r_m02, r_m12, r_m22;
    logic signed [pic_pkg::COORD_W-1:0] r_f1_rx, r_f1_ry;
    logic                               r_f1_last;
    logic                               accept;
    logic [pic_pkg::MQ_CW:0]            occupancy;

    assign occupancy = {1'b0, i_q_count} + (pic_pkg::MQ_CW+1)'(r_f0_v)
                     + (pic_pkg::MQ_CW+1)'(r_f1_v);
    assign full      = occupancy >= (pic_pkg::MQ_CW+1)'(pic_pkg::MQ_DEPTH);
    assign accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
        end else begin
            r_f0_v <= accept;
            r_f1_v <= r_f0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f0_pair <= i_pair;
        end
        r_p00     <= P_W'(i_mat.m00) * P_W'(r_f0_pair.left_x);
        r_p01     <= P_W'(i_mat.m01) * P_W'(r_f0_pair.left_y);
        r_p10     <= P_W'(i_mat.m10) * P_W'(r_f0_pair.left_x);
        r_p11     <= P_W'(i_mat.m11) * P_W'(r_f0_pair.left_y);
        r_p20     <= P_W'(i_mat.m20) * P_W'(r_f0_pair.left_x);
        r_p21     <= P_W'(i_mat.m21) * P_W'(r_f0_pair.left_y);
        r_m02     <= i_mat.m02;
        r_m12     <= i_mat.m12;
        r_m22     <= i_mat.m22;
        r_f1_rx   <= r_f0_pair.right_x;
        r_f1_ry   <= r_f0_pair.right_y;
        r_f1_last <= r_f0_pair.last_pair;
    end

    // q = M * (x, y, 1); the constant term is scaled to Q.20
    always_comb begin
        o_wr_valid          = r_f1_v;
        o_wr_data.q0        = pic_pkg::Q_W'(r_p00) + pic_pkg::Q_W'(r_p01)
                            + (pic_pkg::Q_W'(r_m02) <<< 4);
        o_wr_data.q1        = pic_pkg::Q_W'(r_p10) + pic_pkg::Q_W'(r_p11)
                            + (pic_pkg::Q_W'(r_m12) <<< 4);
        o_wr_data.q2        = pic_pkg::Q_W'(r_p20) + pic_pkg::Q_W'(r_p21)
                            + (pic_pkg::Q_W'(r_m22) <<< 4);
        o_wr_data.right_x   = r_f1_rx;
        o_wr_data.right_y   = r_f1_ry;
        o_wr_data.last_pair = r_f1_last;
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        occupancy <= (pic_pkg::MQ_CW+1)'(pic_pkg::MQ_DEPTH))
        else $error("front: queue credit exceeded");

    a_accept_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> (r_f0_v ##1 r_f1_v))
        else $error("front: accepted beat lost in front stages");

endmodule

// ----- src/pic_mid_queue.sv -----
// Short queue of projected pairs between the front and back ends.
// Depends on pic_pkg.
module pic_mid_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_valid,
    input  pic_pkg::t_proj             i_wr_data,
    input  logic                       i_rd,
    output pic_pkg::t_proj             o_head,
    output logic [pic_pkg::MQ_CW-1:0]  o_count
);

    pic_pkg::t_proj            r_mem [pic_pkg::MQ_DEPTH];
    logic [pic_pkg::MQ_AW-1:0] r_wp, r_rp;
    logic [pic_pkg::MQ_CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr_valid) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_wr_valid, i_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_valid) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

// ----- src/pic_back.sv -----
// Back end: distance test in split-width arithmetic, set counters, result queue.
// Depends on pic_pkg; reads from pic_mid_queue.
module pic_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pic_pkg::t_proj             i_head,
    input  logic [pic_pkg::MQ_CW-1:0]  i_q_count,
    output logic                       o_rd,
    input  logic [15:0]                i_thr,
    output logic                       empty,
    input  logic                       pop,
    output pic_pkg::t_result           o_result
);

    localparam int D_W  = pic_pkg::D_W;
    localparam int SQ_W = pic_pkg::SQ_W;
    localparam int A_W  = D_W - 1;
    localparam int T_W  = 64;
    localparam int AQ_W = pic_pkg::Q_W - 1;

    // B1
    logic                  r_b1_v, r_b1_last, r_b1_zero;
    logic signed [D_W-1:0] r_b1_pr0, r_b1_pr1, r_b1_q0s, r_b1_q1s;
    logic [AQ_W-1:0]       r_b1_aq2;
    // B2
    logic                  r_b2_v, r_b2_last, r_b2_zero;
    logic signed [D_W-1:0] r_b2_d0, r_b2_d1;
    logic [T_W-1:0]        r_b2_t;
    // B3
    logic                  r_b3_v, r_b3_last, r_b3_zero;
    logic [A_W-1:0]        r_b3_a0, r_b3_a1;
    logic [T_W-1:0]        r_b3_t;
    // B4
    logic                  r_b4_v, r_b4_last, r_b4_zero;
    logic [63:0]           r_hh0, r_hl0, r_ll0, r_hh1, r_hl1, r_ll1, r_hht, r_hlt, r_llt;
    // B5
    logic                  r_b5_v, r_b5_last, r_b5_zero;
    logic [SQ_W-1:0]       r_b5_sq0, r_b5_sq1, r_b5_sqt;
    // B6
    logic                  r_b6_v, r_b6_last, r_b6_zero;
    logic [SQ_W-1:0]       r_b6_s, r_b6_tt;

    logic [pic_pkg::PIDX_W-1:0] r_pair_cnt, n_pair_cnt;
    logic [pic_pkg::CNT_W-1:0]  r_inl_cnt, n_inl_cnt, inl_inc;
    logic                       hit;
    pic_pkg::t_result           wr_res;

    pic_pkg::t_result           r_out_mem [pic_pkg::OUT_DEPTH];
    logic [pic_pkg::OUT_AW-1:0] r_out_wp, r_out_rp;
    logic [pic_pkg::OUT_CW-1:0] r_out_count, inflight;
    logic                       out_rd;
    logic signed [pic_pkg::Q_W-1:0] neg_q2;

    assign inflight = pic_pkg::OUT_CW'($countones({r_b1_v, r_b2_v, r_b3_v,
                                                   r_b4_v, r_b5_v, r_b6_v}));
    assign o_rd     = (i_q_count != '0)
                   && ((r_out_count + inflight) < pic_pkg::OUT_CW'(pic_pkg::OUT_DEPTH));
    assign neg_q2   = -i_head.q2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
            r_b5_v <= 1'b0;
            r_b6_v <= 1'b0;
        end else begin
            r_b1_v <= o_rd;
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_b4_v <= r_b3_v;
            r_b5_v <= r_b4_v;
            r_b6_v <= r_b5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        // B1: r*q2, 16*q, |q2|
        r_b1_pr0  <= D_W'(i_head.right_x) * D_W'(i_head.q2);
        r_b1_pr1  <= D_W'(i_head.right_y) * D_W'(i_head.q2);
        r_b1_q0s  <= D_W'(i_head.q0) <<< 4;
        r_b1_q1s  <= D_W'(i_head.q1) <<< 4;
        r_b1_aq2  <= i_head.q2[pic_pkg::Q_W-1] ? neg_q2[AQ_W-1:0] : i_head.q2[AQ_W-1:0];
        r_b1_zero <= (i_head.q2 == '0);
        r_b1_last <= i_head.last_pair;
        // B2: differences, threshold * |q2|
        r_b2_d0   <= r_b1_q0s - r_b1_pr0;
        r_b2_d1   <= r_b1_q1s - r_b1_pr1;
        r_b2_t    <= T_W'(i_thr) * T_W'(r_b1_aq2);
        r_b2_zero <= r_b1_zero;
        r_b2_last <= r_b1_last;
        // B3: magnitudes
        r_b3_a0   <= r_b2_d0[D_W-1] ? A_W'(-r_b2_d0) : r_b2_d0[A_W-1:0];
        r_b3_a1   <= r_b2_d1[D_W-1] ? A_W'(-r_b2_d1) : r_b2_d1[A_W-1:0];
        r_b3_t    <= r_b2_t;
        r_b3_zero <= r_b2_zero;
        r_b3_last <= r_b2_last;
        // B4: 32x32 partial products of each square
        r_hh0     <= 64'(r_b3_a0[A_W-1:32]) * 64'(r_b3_a0[A_W-1:32]);
        r_hl0     <= 64'(r_b3_a0[A_W-1:32]) * 64'(r_b3_a0[31:0]);
        r_ll0     <= 64'(r_b3_a0[31:0]) * 64'(r_b3_a0[31:0]);
        r_hh1     <= 64'(r_b3_a1[A_W-1:32]) * 64'(r_b3_a1[A_W-1:32]);
        r_hl1     <= 64'(r_b3_a1[A_W-1:32]) * 64'(r_b3_a1[31:0]);
        r_ll1     <= 64'(r_b3_a1[31:0]) * 64'(r_b3_a1[31:0]);
        r_hht     <= 64'(r_b3_t[63:32]) * 64'(r_b3_t[63:32]);
        r_hlt     <= 64'(r_b3_t[63:32]) * 64'(r_b3_t[31:0]);
        r_llt     <= 64'(r_b3_t[31:0]) * 64'(r_b3_t[31:0]);
        r_b4_zero <= r_b3_zero;
        r_b4_last <= r_b3_last;
        // B5: assemble squares
        r_b5_sq0  <= {r_hh0, 64'd0} + {31'd0, r_hl0, 33'd0} + {64'd0, r_ll0};
        r_b5_sq1  <= {r_hh1, 64'd0} + {31'd0, r_hl1, 33'd0} + {64'd0, r_ll1};
        r_b5_sqt  <= {r_hht, 64'd0} + {31'd0, r_hlt, 33'd0} + {64'd0, r_llt};
        r_b5_zero <= r_b4_zero;
        r_b5_last <= r_b4_last;
        // B6: sum of squares
        r_b6_s    <= r_b5_sq0 + r_b5_sq1;
        r_b6_tt   <= r_b5_sqt;
        r_b6_zero <= r_b5_zero;
        r_b6_last <= r_b5_last;
    end

    // B7: compare, count, enqueue result
    always_comb begin
        hit     = !r_b6_zero && (r_b6_s <= r_b6_tt);
        inl_inc = (hit && (r_inl_cnt < pic_pkg::CNT_W'(pic_pkg::MAX_POINTS)))
                ? r_inl_cnt + 1'b1 : r_inl_cnt;
        wr_res.is_inlier    = hit;
        wr_res.point_index  = r_pair_cnt;
        wr_res.inlier_count = inl_inc;
        wr_res.set_done     = r_b6_last;
        n_pair_cnt = r_pair_cnt;
        n_inl_cnt  = r_inl_cnt;
        if (r_b6_v) begin
            if (r_b6_last) begin
                n_pair_cnt = '0;
                n_inl_cnt  = '0;
            end else begin
                n_inl_cnt  = inl_inc;
                n_pair_cnt = (r_pair_cnt == pic_pkg::PIDX_W'(pic_pkg::MAX_POINTS - 1))
                           ? '0 : r_pair_cnt + 1'b1;
            end
        end
    end

    assign out_rd   = pop && !empty;
    assign empty    = (r_out_count == '0);
    assign o_result = r_out_mem[r_out_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_cnt  <= '0;
            r_inl_cnt   <= '0;
            r_out_wp    <= '0;
            r_out_rp    <= '0;
            r_out_count <= '0;
        end else begin
            r_pair_cnt <= n_pair_cnt;
            r_inl_cnt  <= n_inl_cnt;
            if (r_b6_v) begin
                r_out_wp <= r_out_wp + 1'b1;
            end
            if (out_rd) begin
                r_out_rp <= r_out_rp + 1'b1;
            end
            case ({r_b6_v, out_rd})
                2'b10:   r_out_count <= r_out_count + 1'b1;
                2'b01:   r_out_count <= r_out_count - 1'b1;
                default: r_out_count <= r_out_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b6_v) begin
            r_out_mem[r_out_wp] <= wr_res;
        end
    end

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_count + inflight) <= pic_pkg::OUT_CW'(pic_pkg::OUT_DEPTH))
        else $error("back: result queue credit exceeded");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b6_v |-> (r_out_count < pic_pkg::OUT_CW'(pic_pkg::OUT_DEPTH)))
        else $error("back: write into full result queue");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inl_cnt <= pic_pkg::CNT_W'(pic_pkg::MAX_POINTS))
        else $error("back: inlier count past saturation");

endmodule

// ----- src/projective_inlier_counter_top.sv -----
// Throughput is one pair per clock sustained while pop keeps up with the results:
// every unit in both ends is fully pipelined and the 4-entry queue between them
// and the 16-entry result queue absorb stalls. A pair passes the two front
// stages, the middle queue and the six back stages, with the 128-bit squares
// split into 32x32 partial products. full rises when the middle queue plus the two
// front stages hold four pairs; the back end stops reading the middle queue
// when the result queue and its six stages hold sixteen. Configuration writes
// are always ready and must only be made while no pair is in flight.
// Depends on pic_pkg, pic_front, pic_mid_queue and pic_back.
module projective_inlier_counter_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  pic_pkg::t_pair_in       i_pair,
    output logic                    empty,
    input  logic                    pop,
    output pic_pkg::t_result        o_result,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [63:0]             i_cfg_data
);

    logic [63:0]               r_coef_a, r_coef_b, r_coef_c, r_coef_d;
    logic [31:0]               r_coef_br;
    logic [15:0]               r_thr;
    pic_pkg::t_matrix          mat;
    logic                      q_wr_valid, q_rd;
    pic_pkg::t_proj            q_wr_data, q_head;
    logic [pic_pkg::MQ_CW-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a  <= 64'd65536;
            r_coef_b  <= 64'd0;
            r_coef_c  <= 64'd65536;
            r_coef_d  <= 64'd0;
            r_coef_br <= 32'd65536;
            r_thr     <= 16'd96;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pic_pkg::CFG_COEF_PAIR_A:       r_coef_a  <= i_cfg_data;
                pic_pkg::CFG_COEF_PAIR_B:       r_coef_b  <= i_cfg_data;
                pic_pkg::CFG_COEF_PAIR_C:       r_coef_c  <= i_cfg_data;
                pic_pkg::CFG_COEF_PAIR_D:       r_coef_d  <= i_cfg_data;
                pic_pkg::CFG_COEF_BOTTOM_RIGHT: r_coef_br <= i_cfg_data[31:0];
                pic_pkg::CFG_DIST_THRESHOLD:    r_thr     <= i_cfg_data[15:0];
                default:                        r_thr     <= r_thr;
            endcase
        end
    end

    always_comb begin
        mat.m00 = r_coef_a[31:0];
        mat.m01 = r_coef_a[63:32];
        mat.m02 = r_coef_b[31:0];
        mat.m10 = r_coef_b[63:32];
        mat.m11 = r_coef_c[31:0];
        mat.m12 = r_coef_c[63:32];
        mat.m20 = r_coef_d[31:0];
        mat.m21 = r_coef_d[63:32];
        mat.m22 = r_coef_br;
    end

    pic_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_pair     (i_pair),
        .i_mat      (mat),
        .i_q_count  (q_count),
        .o_wr_valid (q_wr_valid),
        .o_wr_data  (q_wr_data)
    );

    pic_mid_queue u_mid_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (q_wr_valid),
        .i_wr_data  (q_wr_data),
        .i_rd       (q_rd),
        .o_head     (q_head),
        .o_count    (q_count)
    );

    pic_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_count  (q_count),
        .o_rd       (q_rd),
        .i_thr      (r_thr),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result)
    );

endmodule

// ----- test/pic_checker.sv -----
// Scoreboard for the projective inlier counter: watches the pair, result and
// register channels, predicts every result and compares it with what pops out.
// Depends on pic_pkg.
module pic_checker
    import pic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_pair_in    i_pair,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_result     i_result,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    logic [63:0] coef_a, coef_b, coef_c, coef_d;
    logic [31:0] coef_m22;
    logic [15:0] thr;
    int unsigned pair_ctr;
    int unsigned inlier_ctr;
    int          n_err = 0;
    t_result     expected_q[$];

    // exact test at full width, no division
    function automatic logic pair_passes(input t_pair_in p);
        logic signed [79:0] lx, ly, rx, ry, q0, q1, q2, d0, d1;
        logic [159:0] a0, a1, aq2, t;
        lx = p.left_x;
        ly = p.left_y;
        rx = p.right_x;
        ry = p.right_y;
        q0 = $signed(coef_a[31:0]) * lx + $signed(coef_a[63:32]) * ly
             + $signed(coef_b[31:0]) * 16;
        q1 = $signed(coef_b[63:32]) * lx + $signed(coef_c[31:0]) * ly
             + $signed(coef_c[63:32]) * 16;
        q2 = $signed(coef_d[31:0]) * lx + $signed(coef_d[63:32]) * ly
             + $signed(coef_m22) * 16;
        if (q2 == 0) return 1'b0;
        d0  = q0 * 16 - rx * q2;
        d1  = q1 * 16 - ry * q2;
        a0  = (d0 < 0) ? -d0 : d0;
        a1  = (d1 < 0) ? -d1 : d1;
        aq2 = (q2 < 0) ? -q2 : q2;
        t   = aq2 * thr;
        return (a0 * a0 + a1 * a1) <= (t * t);
    endfunction

    function automatic t_result score_pair(input t_pair_in p);
        t_result r;
        logic    hit;
        hit = pair_passes(p);
        if (hit && inlier_ctr < MAX_POINTS) inlier_ctr++;
        r.is_inlier    = hit;
        r.point_index  = PIDX_W'(pair_ctr);
        r.inlier_count = CNT_W'(inlier_ctr);
        r.set_done     = p.last_pair;
        if (p.last_pair) begin
            pair_ctr   = 0;
            inlier_ctr = 0;
        end else begin
            pair_ctr++;
            if (pair_ctr >= MAX_POINTS) pair_ctr = 0;
        end
        return r;
    endfunction

    task automatic report(input string msg);
        n_err++;
        if (n_err <= 10) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            coef_a     = 64'h0000_0000_0001_0000;
            coef_b     = '0;
            coef_c     = 64'h0000_0000_0001_0000;
            coef_d     = '0;
            coef_m22   = 32'h0001_0000;
            thr        = 16'd96;
            pair_ctr   = 0;
            inlier_ctr = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COEF_PAIR_A:       coef_a   = i_cfg_data;
                    CFG_COEF_PAIR_B:       coef_b   = i_cfg_data;
                    CFG_COEF_PAIR_C:       coef_c   = i_cfg_data;
                    CFG_COEF_PAIR_D:       coef_d   = i_cfg_data;
                    CFG_COEF_BOTTOM_RIGHT: coef_m22 = i_cfg_data[31:0];
                    CFG_DIST_THRESHOLD:    thr      = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (expected_q.size() == 0) begin
                    report($sformatf({"unexpected result beat: inlier=%0d index=%0d ",
                        "count=%0d done=%0d"},
                        i_result.is_inlier, i_result.point_index,
                        i_result.inlier_count, i_result.set_done));
                end else begin
                    want = expected_q.pop_front();
                    if (i_result.is_inlier !== want.is_inlier
                        || i_result.point_index !== want.point_index
                        || i_result.inlier_count !== want.inlier_count
                        || i_result.set_done !== want.set_done) begin
                        report($sformatf({"result mismatch: expected inlier=%0d index=%0d ",
                            "count=%0d done=%0d, got inlier=%0d index=%0d count=%0d done=%0d"},
                            want.is_inlier, want.point_index, want.inlier_count,
                            want.set_done, i_result.is_inlier, i_result.point_index,
                            i_result.inlier_count, i_result.set_done));
                    end
                end
            end
            if (i_push && !i_full) begin
                expected_q.insert(expected_q.size(), score_pair(i_pair));
            end
        end
        o_errors  <= n_err;
        o_pending <= expected_q.size();
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for projective_inlier_counter_top: drives pairs and register
// writes under several idle patterns; pic_checker predicts and compares.
// Depends on pic_pkg, pic_checker and the block's sources.
module tb;
    import pic_pkg::*;

    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;
    localparam int QUIET_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    t_pair_in    pair_in;
    logic        empty;
    logic        pop = 1'b0;
    t_result     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          errors;
    int          pending;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          quiet = 0;
    logic [63:0] reg_shadow [0:5];

    projective_inlier_counter_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_pair      (pair_in),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pic_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_pair      (pair_in),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_result    (result),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic t_pair_in pair_of(input int lx, ly, rx, ry, input logic last);
        t_pair_in p;
        p.left_x    = 16'(lx);
        p.left_y    = 16'(ly);
        p.right_x   = 16'(rx);
        p.right_y   = 16'(ry);
        p.last_pair = last;
        return p;
    endfunction

    function automatic logic signed [15:0] clamp16(input logic signed [79:0] v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // right point = projected left point plus an offset
    function automatic t_pair_in aim_pair(input logic signed [15:0] lx, ly,
                                          input int nx, ny, input logic last);
        logic signed [79:0] q0, q1, q2, ex, ey;
        t_pair_in p;
        q0 = $signed(reg_shadow[0][31:0]) * lx + $signed(reg_shadow[0][63:32]) * ly
             + $signed(reg_shadow[1][31:0]) * 16;
        q1 = $signed(reg_shadow[1][63:32]) * lx + $signed(reg_shadow[2][31:0]) * ly
             + $signed(reg_shadow[2][63:32]) * 16;
        q2 = $signed(reg_shadow[3][31:0]) * lx + $signed(reg_shadow[3][63:32]) * ly
             + $signed(reg_shadow[4][31:0]) * 16;
        if (q2 == 0) begin
            ex = lx;
            ey = ly;
        end else begin
            ex = q0 * 16 / q2;
            ey = q1 * 16 / q2;
        end
        p.left_x    = lx;
        p.left_y    = ly;
        p.right_x   = clamp16(ex + nx);
        p.right_y   = clamp16(ey + ny);
        p.last_pair = last;
        return p;
    endfunction

    task automatic send_pair(input t_pair_in p);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        pair_in <= p;
        push    <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx <= 3'(CFG_DIST_THRESHOLD)) reg_shadow[idx] = val;
        @(posedge clk);
    endtask

    task automatic write_homography();
        int m00, m01, m02, m10, m11, m12, m20, m21;
        m00 = 65536 + int'($urandom_range(8192)) - 4096;
        m01 = int'($urandom_range(4096)) - 2048;
        m02 = int'($urandom_range(2097152)) - 1048576;
        m10 = int'($urandom_range(4096)) - 2048;
        m11 = 65536 + int'($urandom_range(8192)) - 4096;
        m12 = int'($urandom_range(2097152)) - 1048576;
        m20 = int'($urandom_range(16)) - 8;
        m21 = int'($urandom_range(16)) - 8;
        write_reg(CFG_COEF_PAIR_A, {32'(m01), 32'(m00)});
        write_reg(CFG_COEF_PAIR_B, {32'(m10), 32'(m02)});
        write_reg(CFG_COEF_PAIR_C, {32'(m12), 32'(m11)});
        write_reg(CFG_COEF_PAIR_D, {32'(m21), 32'(m20)});
        write_reg(CFG_COEF_BOTTOM_RIGHT, 64'h0001_0000);
        write_reg(CFG_DIST_THRESHOLD, 64'($urandom_range(400)));
    endtask

    task automatic write_matrix(input logic [63:0] a, b, c, d, m22, thr);
        write_reg(CFG_COEF_PAIR_A, a);
        write_reg(CFG_COEF_PAIR_B, b);
        write_reg(CFG_COEF_PAIR_C, c);
        write_reg(CFG_COEF_PAIR_D, d);
        write_reg(CFG_COEF_BOTTOM_RIGHT, m22);
        write_reg(CFG_DIST_THRESHOLD, thr);
    endtask

    task automatic apply_setting(input int k);
        case (k)
            0: write_matrix(64'h1_0000, 64'h0, 64'h1_0000, 64'h0, 64'h1_0000, 64'h0);
            1: write_matrix(64'h1_0000, 64'h0, 64'h1_0000, 64'h0001_0000_0001_0000,
                            64'h0, 64'd200);
            2: write_matrix({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
            3: write_homography();
            4: write_matrix('1, '1, '1, '1, '1, '1);
            5: write_matrix({2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                            {2{32'h8000_0000}}, 64'h8000_0000, 64'd1);
            6: write_matrix({2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                            {2{32'h7FFF_FFFF}}, 64'h7FFF_FFFF, 64'hFFFF);
            default: begin
                write_reg(CFG_UNMAPPED_LO, {$urandom, $urandom});
                write_homography();
                write_reg(CFG_UNMAPPED_HI, {$urandom, $urandom});
            end
        endcase
    endtask

    task automatic random_items(input int count);
        logic signed [15:0] lx, ly;
        int span;
        t_pair_in p;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15) begin
                p = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0};
            end else begin
                if ($urandom_range(4) == 0) begin
                    lx = 16'($urandom);
                    ly = 16'($urandom);
                end else begin
                    lx = 16'($urandom_range(4095)) - 16'd2048;
                    ly = 16'($urandom_range(4095)) - 16'd2048;
                end
                if ($urandom_range(9) == 0) ly = -lx;
                if ($urandom_range(19) == 0) lx = '0;
                span = int'(reg_shadow[5][15:0]) + 2;
                p = aim_pair(lx, ly, int'($urandom_range(2 * span)) - span,
                             int'($urandom_range(2 * span)) - span, 1'b0);
            end
            p.last_pair = ($urandom_range(15) == 0);
            send_pair(p);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        push      = 1'b0;
        pair_in   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COEF_PAIR_A;
        cfg_data  = '0;
        reg_shadow[0] = 64'h1_0000;
        reg_shadow[1] = 64'h0;
        reg_shadow[2] = 64'h1_0000;
        reg_shadow[3] = 64'h0;
        reg_shadow[4] = 64'h1_0000;
        reg_shadow[5] = 64'd96;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset matrix is identity, limit 6.0 px
        send_pair(pair_of(0, 0, 0, 0, 1'b0));
        send_pair(pair_of(32767, -32768, 32767, -32768, 1'b0));
        send_pair(pair_of(-32768, 32767, 32767, -32768, 1'b0));
        send_pair(pair_of(100, 200, 196, 200, 1'b0));
        send_pair(pair_of(100, 200, 197, 200, 1'b0));
        send_pair(pair_of(-50, -50, 17, 17, 1'b0));
        send_pair(pair_of(-50, -50, 18, 18, 1'b0));
        send_pair(pair_of(1, 2, 1, 2, 1'b1));
        send_pair(pair_of(5, 5, 5, 5, 1'b0));
        send_pair(pair_of(-1, -1, -1, -1, 1'b1));
        wait_drained();

        // w = x + y: zero denominator on the anti-diagonal
        write_reg(CFG_COEF_PAIR_D, 64'h0001_0000_0001_0000);
        write_reg(CFG_COEF_BOTTOM_RIGHT, 64'h0);
        send_pair(pair_of(0, 0, 0, 0, 1'b0));
        send_pair(pair_of(9, -9, 0, 0, 1'b0));
        send_pair(pair_of(-32768, 32767, -32768, 32767, 1'b1));
        wait_drained();

        for (int k = 0; k < 8; k++) begin
            send_idle_pct = (k % 4 == 1) ? 49 : (k % 4 == 3) ? 22 : 0;
            stall_pct     = (k % 4 == 2) ? 49 : (k % 4 == 3) ? 22 : 0;
            apply_setting(k);
            random_items(105);
            wait_drained();
        end

        repeat (32) @(posedge clk);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
